>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/wrp_pkg.sv
package wrp_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_WINDOW = 16;
	localparam int PIXEL_BITS = 8;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WIN_W = $clog2(MAX_WINDOW);

	localparam int IMG_W_BITS = 9;
	localparam int IMG_H_BITS = 13;
	localparam int WIN_H_BITS = 5;
	localparam int WIN_W_BITS = 5;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd2;
	localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd3;

	typedef struct packed {
		logic [COL_W-1:0] w_m1;
		logic [ROW_W-1:0] h_m1;
		logic [WIN_W-1:0] wh_m1;
		logic [WIN_W-1:0] ww_m1;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] wi;
		logic             first;
		logic             result;
		logic [ROW_W-1:0] band;
		logic             frame_last;
	} scan_t;

endpackage

>>> hdl/wrp_regs.sv
module wrp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wrp_pkg::ADDR_W-1:0]   paddr,
	input  logic [wrp_pkg::DATA_W-1:0]   pwdata,
	output logic [wrp_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output wrp_pkg::cfg_t                cfg,
	output logic                         restart
);

	logic [wrp_pkg::IMG_W_BITS-1:0] img_w_q;
	logic [wrp_pkg::IMG_H_BITS-1:0] img_h_q;
	logic [wrp_pkg::WIN_H_BITS-1:0] win_h_q;
	logic [wrp_pkg::WIN_W_BITS-1:0] win_w_q;
	logic [1:0]                     idx;
	logic                           we;

	assign pready  = 1'b1;
	assign idx     = paddr[3:2];
	assign we      = psel && penable && pwrite && pready;
	assign restart = we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= wrp_pkg::IMG_W_BITS'(6);
			img_h_q <= wrp_pkg::IMG_H_BITS'(6);
			win_h_q <= wrp_pkg::WIN_H_BITS'(2);
			win_w_q <= wrp_pkg::WIN_W_BITS'(4);
		end else if (we) begin
			unique case (idx)
				wrp_pkg::REG_IMAGE_WIDTH:   img_w_q <= pwdata[wrp_pkg::IMG_W_BITS-1:0];
				wrp_pkg::REG_IMAGE_HEIGHT:  img_h_q <= pwdata[wrp_pkg::IMG_H_BITS-1:0];
				wrp_pkg::REG_WINDOW_HEIGHT: win_h_q <= pwdata[wrp_pkg::WIN_H_BITS-1:0];
				wrp_pkg::REG_WINDOW_WIDTH:  win_w_q <= pwdata[wrp_pkg::WIN_W_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wrp_pkg::REG_IMAGE_WIDTH:   prdata = wrp_pkg::DATA_W'(img_w_q);
			wrp_pkg::REG_IMAGE_HEIGHT:  prdata = wrp_pkg::DATA_W'(img_h_q);
			wrp_pkg::REG_WINDOW_HEIGHT: prdata = wrp_pkg::DATA_W'(win_h_q);
			wrp_pkg::REG_WINDOW_WIDTH:  prdata = wrp_pkg::DATA_W'(win_w_q);
			default:                    prdata = '0;
		endcase
	end

	// Zero acts as one and values above the bound act as the bound.
	always_comb begin
		if (img_w_q == '0)
			cfg.w_m1 = '0;
		else if (img_w_q > wrp_pkg::IMG_W_BITS'(wrp_pkg::MAX_WIDTH))
			cfg.w_m1 = wrp_pkg::COL_W'(wrp_pkg::MAX_WIDTH - 1);
		else
			cfg.w_m1 = wrp_pkg::COL_W'(img_w_q - 1'b1);

		if (img_h_q == '0)
			cfg.h_m1 = '0;
		else if (img_h_q > wrp_pkg::IMG_H_BITS'(wrp_pkg::MAX_HEIGHT))
			cfg.h_m1 = wrp_pkg::ROW_W'(wrp_pkg::MAX_HEIGHT - 1);
		else
			cfg.h_m1 = wrp_pkg::ROW_W'(img_h_q - 1'b1);

		if (win_h_q == '0)
			cfg.wh_m1 = '0;
		else if (win_h_q > wrp_pkg::WIN_H_BITS'(wrp_pkg::MAX_WINDOW))
			cfg.wh_m1 = wrp_pkg::WIN_W'(wrp_pkg::MAX_WINDOW - 1);
		else
			cfg.wh_m1 = wrp_pkg::WIN_W'(win_h_q - 1'b1);

		if (win_w_q == '0)
			cfg.ww_m1 = '0;
		else if (win_w_q > wrp_pkg::WIN_W_BITS'(wrp_pkg::MAX_WINDOW))
			cfg.ww_m1 = wrp_pkg::WIN_W'(wrp_pkg::MAX_WINDOW - 1);
		else
			cfg.ww_m1 = wrp_pkg::WIN_W'(win_w_q - 1'b1);
	end

endmodule

>>> hdl/wrp_scan.sv
module wrp_scan (
	input  logic          clk,
	input  logic          arst_n,
	input  wrp_pkg::cfg_t cfg,
	input  logic          restart,
	input  logic          accept,
	output wrp_pkg::scan_t scan
);

	logic [wrp_pkg::COL_W-1:0] col_q;
	logic [wrp_pkg::ROW_W-1:0] row_q;
	logic [wrp_pkg::WIN_W-1:0] rib_q;
	logic [wrp_pkg::WIN_W-1:0] ciw_q;
	logic [wrp_pkg::COL_W-1:0] wi_q;
	logic [wrp_pkg::ROW_W-1:0] band_q;

	logic row_end;
	logic row_last;
	logic frame_end;
	logic win_col_end;
	logic band_row_end;
	logic band_wrap;

	assign row_end      = col_q >= cfg.w_m1;
	assign row_last     = row_q >= cfg.h_m1;
	assign frame_end    = row_end && row_last;
	assign win_col_end  = (ciw_q >= cfg.ww_m1) || row_end;
	assign band_wrap    = rib_q >= cfg.wh_m1;
	assign band_row_end = band_wrap || row_last;

	assign scan.wi         = wi_q;
	assign scan.first      = (rib_q == '0) && (ciw_q == '0);
	assign scan.result     = win_col_end && band_row_end;
	assign scan.band       = band_q;
	assign scan.frame_last = frame_end;

	// The band counter stands in for the row count divided by the window height.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rib_q  <= '0;
			ciw_q  <= '0;
			wi_q   <= '0;
			band_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			rib_q  <= '0;
			ciw_q  <= '0;
			wi_q   <= '0;
			band_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				ciw_q <= '0;
				wi_q  <= '0;
				if (frame_end) begin
					row_q  <= '0;
					rib_q  <= '0;
					band_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (band_wrap) begin
						rib_q  <= '0;
						band_q <= band_q + 1'b1;
					end else begin
						rib_q <= rib_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (ciw_q >= cfg.ww_m1) begin
					ciw_q <= '0;
					wi_q  <= wi_q + 1'b1;
				end else begin
					ciw_q <= ciw_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/wrp_pool.sv
module wrp_pool (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [wrp_pkg::PIXEL_BITS-1:0] pixel,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  wrp_pkg::scan_t                scan,
	output logic                          accept,
	output logic [wrp_pkg::PIXEL_BITS-1:0] range_value,
	output logic [wrp_pkg::ROW_W-1:0]     out_row,
	output logic [wrp_pkg::COL_W-1:0]     out_col,
	output logic                          frame_last,
	output logic                          out_valid,
	input  logic                          out_stall
);

	logic [2*wrp_pkg::PIXEL_BITS-1:0] band_mem [wrp_pkg::MAX_WIDTH];

	logic                             valid_s1;
	logic [wrp_pkg::PIXEL_BITS-1:0]   pix_s1;
	logic [wrp_pkg::COL_W-1:0]        addr_s1;
	logic                             first_s1;
	logic                             res_s1;
	logic [wrp_pkg::ROW_W-1:0]        row_s1;
	logic                             last_s1;
	logic                             byp_s1;
	logic [2*wrp_pkg::PIXEL_BITS-1:0] rd_s1;
	logic [2*wrp_pkg::PIXEL_BITS-1:0] fwd_q;
	logic                             out_valid_q;

	logic                           out_ready;
	logic                           adv_s1;
	logic [wrp_pkg::PIXEL_BITS-1:0] old_max;
	logic [wrp_pkg::PIXEL_BITS-1:0] old_min;
	logic [wrp_pkg::PIXEL_BITS-1:0] new_max;
	logic [wrp_pkg::PIXEL_BITS-1:0] new_min;

	assign out_ready = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && (!res_s1 || out_ready);
	assign in_stall  = valid_s1 && !adv_s1;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// The entry written at the same edge as a read is taken from the forward register.
	assign old_max = byp_s1 ? fwd_q[2*wrp_pkg::PIXEL_BITS-1:wrp_pkg::PIXEL_BITS]
		: rd_s1[2*wrp_pkg::PIXEL_BITS-1:wrp_pkg::PIXEL_BITS];
	assign old_min = byp_s1 ? fwd_q[wrp_pkg::PIXEL_BITS-1:0]
		: rd_s1[wrp_pkg::PIXEL_BITS-1:0];

	always_comb begin
		if (first_s1) begin
			new_max = pix_s1;
			new_min = pix_s1;
		end else begin
			new_max = (pix_s1 > old_max) ? pix_s1 : old_max;
			new_min = (pix_s1 < old_min) ? pix_s1 : old_min;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			band_mem[addr_s1] <= {new_max, new_min};
		if (accept)
			rd_s1 <= band_mem[scan.wi];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixel;
			addr_s1  <= scan.wi;
			first_s1 <= scan.first;
			res_s1   <= scan.result;
			row_s1   <= scan.band;
			last_s1  <= scan.frame_last;
			byp_s1   <= adv_s1 && (addr_s1 == scan.wi);
		end
		if (adv_s1)
			fwd_q <= {new_max, new_min};
		if (adv_s1 && res_s1) begin
			range_value <= new_max - new_min;
			out_row     <= row_s1;
			out_col     <= addr_s1;
			frame_last  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;

			if (adv_s1 && res_s1)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hdl/window_range_pooling_core.sv
// A window's last pixel is held in the pixel stage, then its result in the output register.
// One pixel per cycle unless stalled; the column store is read and written once per pixel.
// A result held at the output while stalled holds the pixel stage and then the input.
// Reset clears the frame position and the pipeline valid flags; the column store is not
// cleared, since each entry is written on the first pixel of its window.
module window_range_pooling_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wrp_pkg::ADDR_W-1:0]     paddr,
	input  logic [wrp_pkg::DATA_W-1:0]     pwdata,
	output logic [wrp_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  logic [wrp_pkg::PIXEL_BITS-1:0] pixel,
	input  logic                           in_valid,
	output logic                           in_stall,
	output logic [wrp_pkg::PIXEL_BITS-1:0] range_value,
	output logic [wrp_pkg::ROW_W-1:0]      out_row,
	output logic [wrp_pkg::COL_W-1:0]      out_col,
	output logic                           frame_last,
	output logic                           out_valid,
	input  logic                           out_stall
);

	`include "assert_macros.svh"

	wrp_pkg::cfg_t  cfg;
	wrp_pkg::scan_t scan;
	logic           restart;
	logic           accept;

	wrp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	wrp_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.accept  (accept),
		.scan    (scan)
	);

	wrp_pool u_pool (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.scan        (scan),
		.accept      (accept),
		.range_value (range_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.frame_last  (frame_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

	`ASSERT_CLK(a_stall_cause, in_stall |-> (out_valid && out_stall), "stall without output stall")
	`ASSERT_CLK(a_restart_origin, restart |=> scan.first, "write did not restart the frame")
	`ASSERT_CLK(a_wrap, (accept && scan.frame_last && !restart) |=> scan.first, "no wrap at frame end")
	`ASSERT_ALWAYS(a_reset_no_stall, !arst_n |-> !in_stall, "input stalled during reset")

endmodule

>>> dv/tb_window_range_pooling_core.sv
`timescale 1ns / 1ps
module tb_window_range_pooling_core;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [wrp_pkg::PIXEL_BITS-1:0] range_value;
		logic [wrp_pkg::ROW_W-1:0]      row;
		logic [wrp_pkg::COL_W-1:0]      col;
		logic                           last;
	} window_result_t;

	class range_scoreboard;
		logic [wrp_pkg::IMG_W_BITS-1:0] img_w;
		logic [wrp_pkg::IMG_H_BITS-1:0] img_h;
		logic [wrp_pkg::WIN_H_BITS-1:0] win_h;
		logic [wrp_pkg::WIN_W_BITS-1:0] win_w;
		logic [wrp_pkg::PIXEL_BITS-1:0] col_max [wrp_pkg::MAX_WIDTH];
		logic [wrp_pkg::PIXEL_BITS-1:0] col_min [wrp_pkg::MAX_WIDTH];
		int unsigned row_pos, col_pos, band_row, win_col, win_idx;
		window_result_t expected_q [$];
		int mismatches;
		int checked;

		function new();
			img_w = wrp_pkg::IMG_W_BITS'(6);
			img_h = wrp_pkg::IMG_H_BITS'(6);
			win_h = wrp_pkg::WIN_H_BITS'(2);
			win_w = wrp_pkg::WIN_W_BITS'(4);
			mismatches = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			row_pos = 0;
			col_pos = 0;
			band_row = 0;
			win_col = 0;
			win_idx = 0;
		endfunction

		function int unsigned bounded(int unsigned v, int unsigned hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(logic [1:0] idx, logic [wrp_pkg::DATA_W-1:0] data);
			case (idx)
				wrp_pkg::REG_IMAGE_WIDTH: img_w = data[wrp_pkg::IMG_W_BITS-1:0];
				wrp_pkg::REG_IMAGE_HEIGHT: img_h = data[wrp_pkg::IMG_H_BITS-1:0];
				wrp_pkg::REG_WINDOW_HEIGHT: win_h = data[wrp_pkg::WIN_H_BITS-1:0];
				wrp_pkg::REG_WINDOW_WIDTH: win_w = data[wrp_pkg::WIN_W_BITS-1:0];
				default: return;
			endcase
			restart();
		endfunction

		function void note_pixel(logic [wrp_pkg::PIXEL_BITS-1:0] p);
			int unsigned w, h, wh, ww, slot;
			bit row_end, frame_end, col_end, band_end;
			window_result_t res;
			w = bounded(img_w, wrp_pkg::MAX_WIDTH);
			h = bounded(img_h, wrp_pkg::MAX_HEIGHT);
			wh = bounded(win_h, wrp_pkg::MAX_WINDOW);
			ww = bounded(win_w, wrp_pkg::MAX_WINDOW);
			slot = win_idx % wrp_pkg::MAX_WIDTH;
			row_end = col_pos >= w - 1;
			frame_end = row_end && row_pos >= h - 1;
			col_end = win_col >= ww - 1 || row_end;
			band_end = band_row >= wh - 1 || row_pos >= h - 1;
			if (band_row == 0 && win_col == 0) begin
				col_max[slot] = p;
				col_min[slot] = p;
			end else begin
				if (p > col_max[slot]) col_max[slot] = p;
				if (p < col_min[slot]) col_min[slot] = p;
			end
			if (col_end && band_end) begin
				res.range_value = col_max[slot] - col_min[slot];
				res.row = wrp_pkg::ROW_W'(row_pos / wh);
				res.col = wrp_pkg::COL_W'(slot);
				res.last = frame_end;
				expected_q.push_back(res);
			end
			if (row_end) begin
				col_pos = 0;
				win_col = 0;
				win_idx = 0;
				if (frame_end) begin
					row_pos = 0;
					band_row = 0;
				end else begin
					row_pos = (row_pos + 1) % wrp_pkg::MAX_HEIGHT;
					band_row = (band_row >= wh - 1) ? 0 : band_row + 1;
				end
			end else begin
				col_pos = (col_pos + 1) % wrp_pkg::MAX_WIDTH;
				if (win_col >= ww - 1) begin
					win_col = 0;
					win_idx = (win_idx + 1) % wrp_pkg::MAX_WIDTH;
				end else begin
					win_col = win_col + 1;
				end
			end
		endfunction

		function void check_result(window_result_t got);
			window_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected window: range %0d row %0d col %0d last %0b",
						got.range_value, got.row, got.col, got.last);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.range_value !== want.range_value || got.row !== want.row ||
					got.col !== want.col || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("window mismatch: expected range %0d row %0d col %0d last %0b",
						want.range_value, want.row, want.col, want.last);
					$display("                 got range %0d row %0d col %0d last %0b",
						got.range_value, got.row, got.col, got.last);
				end
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [wrp_pkg::ADDR_W-1:0]     paddr;
	logic [wrp_pkg::DATA_W-1:0]     pwdata;
	logic [wrp_pkg::DATA_W-1:0]     prdata;
	logic                           pready;
	logic [wrp_pkg::PIXEL_BITS-1:0] pixel;
	logic                           in_valid;
	logic                           in_stall;
	logic [wrp_pkg::PIXEL_BITS-1:0] range_value;
	logic [wrp_pkg::ROW_W-1:0]      out_row;
	logic [wrp_pkg::COL_W-1:0]      out_col;
	logic                           frame_last;
	logic                           out_valid;
	logic                           out_stall;

	range_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int pixels_taken = 0;
	int cycle_count = 0;

	window_range_pooling_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pixel(pixel),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.range_value(range_value),
		.out_row(out_row),
		.out_col(out_col),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 23);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_pixel(pixel);
				pixels_taken++;
			end
			if (out_valid && !out_stall)
				sb.check_result('{range_value, out_row, out_col, frame_last});
		end
	end

	function automatic logic [wrp_pkg::PIXEL_BITS-1:0] random_pixel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return wrp_pkg::PIXEL_BITS'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [wrp_pkg::PIXEL_BITS-1:0] p);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input int unsigned value, input int bits);
		logic [wrp_pkg::DATA_W-1:0] data;
		data = value;
		if ($urandom_range(3) == 0)
			data = data | ($urandom << bits);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned w, h, wh, ww);
		settle();
		apb_write(wrp_pkg::REG_IMAGE_WIDTH, w, wrp_pkg::IMG_W_BITS);
		apb_write(wrp_pkg::REG_IMAGE_HEIGHT, h, wrp_pkg::IMG_H_BITS);
		apb_write(wrp_pkg::REG_WINDOW_HEIGHT, wh, wrp_pkg::WIN_H_BITS);
		apb_write(wrp_pkg::REG_WINDOW_WIDTH, ww, wrp_pkg::WIN_W_BITS);
	endtask

	initial begin
		logic [wrp_pkg::PIXEL_BITS-1:0] first_rows [12];
		int unsigned w, h, wh, ww, fs, count;
		int random_items;
		int phase;

		first_rows = '{
			8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd7,
			8'd255, 8'd0, 8'd3, 8'd200, 8'd17, 8'd90};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pixel <= '0;
		in_valid <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (first_rows[i])
			send_pixel(first_rows[i]);
		configure(3, 2, 16, 20);
		repeat (7) send_pixel(random_pixel());
		configure(0, 0, 0, 0);
		repeat (3) send_pixel(random_pixel());

		random_items = 0;
		phase = 0;
		while (random_items < 400 || phase < 8) begin
			phase++;
			calm = (phase == 3);
			case ($urandom_range(9))
				0: begin
					w = $urandom_range(1) ? 256 : $urandom_range(257, 511);
					h = $urandom_range(0, 2);
				end
				1: begin
					w = $urandom_range(0, 1);
					h = $urandom_range(1, 40);
				end
				2: begin
					w = $urandom_range(1, 40);
					h = $urandom_range(0, 1);
				end
				default: begin
					w = $urandom_range(1, 16);
					h = $urandom_range(1, 16);
				end
			endcase
			wh = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(0, 31);
			ww = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(0, 31);
			if (phase == 5) begin
				w = 8;
				h = 8;
				wh = 1;
				ww = 1;
			end
			configure(w, h, wh, ww);
			fs = sb.bounded(w, wrp_pkg::MAX_WIDTH) * sb.bounded(h, wrp_pkg::MAX_HEIGHT);
			count = $urandom_range(1) ? fs * $urandom_range(1, 2) : $urandom_range(1, fs);
			if (count > 60)
				count = 60;
			if (phase == 3)
				count = 150;
			if (phase == 5) begin
				count = 120;
				hold_req = 1'b1;
			end
			for (int i = 0; i < count; i++) begin
				if (phase == 7 && i == count / 2)
					settle();
				send_pixel(random_pixel());
			end
			random_items += count;
		end
		calm = 1'b0;

		configure(1, 8191, 1, $urandom_range(0, 31));
		repeat (64) send_pixel(random_pixel());
		configure(wrp_pkg::MAX_WIDTH, 2, 1, 1);
		repeat (wrp_pkg::MAX_WIDTH) send_pixel(random_pixel());
		settle();

		$display("%0d pixels over %0d random settings plus directed, tall and wide frames",
			pixels_taken, phase);
		$display("%0d windows checked, including clipped, oversized and out-of-range windows",
			sb.checked);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
